// ===== hdl/imh_pkg.sv =====
// Shared package for the indexed min-heap.
// It holds the default sizes, the request and status codes, and the command
// and status structs between the controller and the datapath. No dependencies.
`default_nettype none
package imh_pkg;
    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_BITS_DEF  = 32;
    localparam int ID_BITS       = 6;
    localparam int ID_COUNT      = 64;
    localparam int KEY_PORT_BITS = 32;
    localparam int OCC_BITS      = 7;
    localparam int REQ_BITS      = 2;
    localparam int STATUS_BITS   = 2;

    localparam logic [REQ_BITS-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_EXTRACT = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_REPLACE = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_NONE    = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_ABSENT = 2'd3;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_INS,
        DP_REP_RD,
        DP_REP_SET,
        DP_EXT_RD,
        DP_EXT_TAKE,
        DP_UP_RD,
        DP_UP_STEP,
        DP_DN_RD,
        DP_DN_STEP,
        DP_PLACE
    } t_dp_op;

    typedef struct packed {
        t_dp_op                 op;
        logic                   fin;
        logic                   fin_ext;
        logic [STATUS_BITS-1:0] fin_status;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic full;
        logic empty;
        logic last_one;
        logic at_root;
        logic up_less;
        logic dn_has;
        logic dn_gt;
    } t_sts;
endpackage
`default_nettype wire

// ===== hdl/imh_ctrl.sv =====
// Controller state machine of the indexed min-heap.
// It sequences the sift walks and issues datapath commands; uses imh_pkg.
`default_nettype none
module imh_ctrl (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    input  wire  [imh_pkg::REQ_BITS-1:0]          i_req_type,
    input  imh_pkg::t_sts                         i_sts,
    output imh_pkg::t_cmd                         o_cmd,
    output logic                                  busy
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_POS    = 8'b0000_0010,
        S_EXT    = 8'b0000_0100,
        S_FIN    = 8'b0000_1000,
        S_UP_RD  = 8'b0001_0000,
        S_UP_CMP = 8'b0010_0000,
        S_DN_RD  = 8'b0100_0000,
        S_DN_CMP = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_rep, n_rep;
    logic   r_ext, n_ext;

    always_comb begin
        n_state = r_state;
        n_rep   = r_rep;
        n_ext   = r_ext;
        o_cmd   = '{op: imh_pkg::DP_NOP, fin: 1'b0, fin_ext: 1'b0,
                    fin_status: imh_pkg::ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.fin = 1'b1;
                    unique case (i_req_type)
                        imh_pkg::REQ_INSERT: begin
                            if (i_sts.hit || i_sts.full) begin
                                o_cmd.fin_status = imh_pkg::ST_FULL;
                            end else begin
                                o_cmd.fin = 1'b0;
                                o_cmd.op  = imh_pkg::DP_INS;
                                n_rep     = 1'b0;
                                n_ext     = 1'b0;
                                n_state   = S_UP_RD;
                            end
                        end
                        imh_pkg::REQ_EXTRACT: begin
                            if (i_sts.empty) begin
                                o_cmd.fin_status = imh_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.fin = 1'b0;
                                o_cmd.op  = imh_pkg::DP_EXT_RD;
                                n_rep     = 1'b0;
                                n_ext     = 1'b1;
                                n_state   = S_EXT;
                            end
                        end
                        imh_pkg::REQ_REPLACE: begin
                            if (!i_sts.hit) begin
                                o_cmd.fin_status = imh_pkg::ST_ABSENT;
                            end else begin
                                o_cmd.fin = 1'b0;
                                o_cmd.op  = imh_pkg::DP_REP_RD;
                                n_rep     = 1'b1;
                                n_ext     = 1'b0;
                                n_state   = S_POS;
                            end
                        end
                        default: begin
                            o_cmd.fin_status = imh_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_POS: begin
                o_cmd.op = imh_pkg::DP_REP_SET;
                n_state  = S_UP_RD;
            end
            S_EXT: begin
                o_cmd.op = imh_pkg::DP_EXT_TAKE;
                n_state  = i_sts.last_one ? S_FIN : S_DN_RD;
            end
            S_FIN: begin
                o_cmd.fin     = 1'b1;
                o_cmd.fin_ext = 1'b1;
                n_state       = S_IDLE;
            end
            S_UP_RD: begin
                if (!i_sts.at_root) begin
                    o_cmd.op = imh_pkg::DP_UP_RD;
                    n_state  = S_UP_CMP;
                end else if (r_rep) begin
                    n_state = S_DN_RD;
                end else begin
                    o_cmd.op      = imh_pkg::DP_PLACE;
                    o_cmd.fin     = 1'b1;
                    o_cmd.fin_ext = r_ext;
                    n_state       = S_IDLE;
                end
            end
            S_UP_CMP: begin
                if (i_sts.up_less) begin
                    o_cmd.op = imh_pkg::DP_UP_STEP;
                    n_state  = S_UP_RD;
                end else if (r_rep) begin
                    n_state = S_DN_RD;
                end else begin
                    o_cmd.op      = imh_pkg::DP_PLACE;
                    o_cmd.fin     = 1'b1;
                    o_cmd.fin_ext = r_ext;
                    n_state       = S_IDLE;
                end
            end
            S_DN_RD: begin
                if (i_sts.dn_has) begin
                    o_cmd.op = imh_pkg::DP_DN_RD;
                    n_state  = S_DN_CMP;
                end else begin
                    o_cmd.op      = imh_pkg::DP_PLACE;
                    o_cmd.fin     = 1'b1;
                    o_cmd.fin_ext = r_ext;
                    n_state       = S_IDLE;
                end
            end
            S_DN_CMP: begin
                if (i_sts.dn_gt) begin
                    o_cmd.op = imh_pkg::DP_DN_STEP;
                    n_state  = S_DN_RD;
                end else begin
                    o_cmd.op      = imh_pkg::DP_PLACE;
                    o_cmd.fin     = 1'b1;
                    o_cmd.fin_ext = r_ext;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rep   <= 1'b0;
            r_ext   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rep   <= n_rep;
            r_ext   <= n_ext;
        end
    end

    assign busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

// ===== hdl/imh_datapath.sv =====
// Datapath of the indexed min-heap: slot memory, position memory, presence
// bits, element count, sift cursor and result registers. Uses imh_pkg.
`default_nettype none
module imh_datapath #(
    parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  imh_pkg::t_cmd                           i_cmd,
    input  wire  [imh_pkg::ID_BITS-1:0]             i_elem_id,
    input  wire  [imh_pkg::KEY_PORT_BITS-1:0]       i_new_key,
    output imh_pkg::t_sts                           o_sts,
    output logic                                    o_done,
    output logic [imh_pkg::STATUS_BITS-1:0]         o_status,
    output logic [imh_pkg::ID_BITS-1:0]             o_out_elem,
    output logic [imh_pkg::KEY_PORT_BITS-1:0]       o_out_key,
    output logic [imh_pkg::OCC_BITS-1:0]            o_occupancy
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = KEY_BITS;
    localparam int IB = imh_pkg::ID_BITS;
    localparam int EW = KW + IB;

    logic [EW-1:0]                 r_slot_mem [CAPACITY];
    logic [AW-1:0]                 r_pos_mem  [imh_pkg::ID_COUNT];
    logic [EW-1:0]                 r_rd0, r_rd1;
    logic [AW-1:0]                 r_pos_rd;
    logic [imh_pkg::ID_COUNT-1:0]  r_present;
    logic [CW-1:0]                 r_count;
    logic [AW-1:0]                 r_cur;
    logic [EW-1:0]                 r_mov;
    logic [IB-1:0]                 r_oelem;
    logic [KW-1:0]                 r_okey;

    logic [63:0]   w_kin;
    logic [KW-1:0] w_key;
    logic [63:0]   w_okey64;
    logic [AW-1:0] w_parent;
    logic [CW:0]   w_lft, w_rgt;
    logic          w_rgt_ok, w_take_r;
    logic [EW-1:0] w_pick;
    logic [AW-1:0] w_pick_idx;
    logic [AW-1:0] w_addr0, w_addr1;
    logic          w_wr_en;
    logic [EW-1:0] w_wr_data;

    always_comb begin
        w_kin      = 64'(i_new_key);
        w_key      = w_kin[KW-1:0];
        w_okey64   = 64'(r_okey);
        w_parent   = AW'((r_cur - 1'b1) >> 1);
        w_lft      = (CW + 1)'({r_cur, 1'b1});
        w_rgt      = w_lft + 1'b1;
        w_rgt_ok   = w_rgt < {1'b0, r_count};
        w_take_r   = w_rgt_ok && (r_rd1[EW-1:IB] < r_rd0[EW-1:IB]);
        w_pick     = w_take_r ? r_rd1 : r_rd0;
        w_pick_idx = w_take_r ? w_rgt[AW-1:0] : w_lft[AW-1:0];

        w_addr0   = '0;
        w_addr1   = '0;
        w_wr_en   = 1'b0;
        w_wr_data = r_mov;
        unique case (i_cmd.op)
            imh_pkg::DP_UP_RD: begin
                w_addr0 = w_parent;
            end
            imh_pkg::DP_DN_RD: begin
                w_addr0 = w_lft[AW-1:0];
                w_addr1 = w_rgt[AW-1:0];
            end
            imh_pkg::DP_EXT_RD: begin
                w_addr1 = AW'(r_count - 1'b1);
            end
            imh_pkg::DP_UP_STEP: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_rd0;
            end
            imh_pkg::DP_DN_STEP: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_pick;
            end
            imh_pkg::DP_PLACE: begin
                w_wr_en = 1'b1;
            end
            default: begin
            end
        endcase

        o_sts.hit      = r_present[i_elem_id];
        o_sts.full     = (r_count == CW'(CAPACITY));
        o_sts.empty    = (r_count == '0);
        o_sts.last_one = (r_count == CW'(1));
        o_sts.at_root  = (r_cur == '0);
        o_sts.up_less  = (r_mov[EW-1:IB] < r_rd0[EW-1:IB]);
        o_sts.dn_has   = (w_lft < {1'b0, r_count});
        o_sts.dn_gt    = (r_mov[EW-1:IB] > w_pick[EW-1:IB]);
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_slot_mem[r_cur]            <= w_wr_data;
            r_pos_mem[w_wr_data[IB-1:0]] <= r_cur;
        end
        r_rd0    <= r_slot_mem[w_addr0];
        r_rd1    <= r_slot_mem[w_addr1];
        r_pos_rd <= r_pos_mem[i_elem_id];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            imh_pkg::DP_INS, imh_pkg::DP_REP_RD: begin
                r_mov <= {w_key, i_elem_id};
                r_cur <= AW'(r_count);
            end
            imh_pkg::DP_REP_SET: begin
                r_cur <= r_pos_rd;
            end
            imh_pkg::DP_EXT_TAKE: begin
                r_oelem <= r_rd0[IB-1:0];
                r_okey  <= r_rd0[EW-1:IB];
                r_mov   <= r_rd1;
                r_cur   <= '0;
            end
            imh_pkg::DP_UP_STEP: begin
                r_cur <= w_parent;
            end
            imh_pkg::DP_DN_STEP: begin
                r_cur <= w_pick_idx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_count     <= '0;
            o_done      <= 1'b0;
            o_status    <= imh_pkg::ST_OK;
            o_out_elem  <= '0;
            o_out_key   <= '0;
            o_occupancy <= '0;
        end else begin
            if (i_cmd.op == imh_pkg::DP_INS) begin
                r_present[i_elem_id] <= 1'b1;
                r_count              <= r_count + 1'b1;
            end else if (i_cmd.op == imh_pkg::DP_EXT_TAKE) begin
                r_present[r_rd0[IB-1:0]] <= 1'b0;
                r_count                  <= r_count - 1'b1;
            end
            o_done <= i_cmd.fin;
            if (i_cmd.fin) begin
                o_status    <= i_cmd.fin_status;
                o_out_elem  <= i_cmd.fin_ext ? r_oelem : '0;
                o_out_key   <= i_cmd.fin_ext ? w_okey64[imh_pkg::KEY_PORT_BITS-1:0] : '0;
                o_occupancy <= imh_pkg::OCC_BITS'(r_count);
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/indexed_min_heap.sv =====
// Top level of the indexed min-heap priority queue.
// It joins the controller imh_ctrl and the datapath imh_datapath; uses imh_pkg.
//
// A request is accepted on a rising edge with start high and busy low; it
// carries i_req_type (insert, extract minimum, replace key), i_elem_id and
// i_new_key. Exactly one result beat follows, shown for one cycle with o_done
// high: o_status, o_out_elem, o_out_key and o_occupancy. The receiver cannot
// stall; the result must be taken in that cycle.
// Rejected requests (full, present, empty, absent) and the unused request
// code give their result in the cycle after acceptance.
// A sift level is a registered read of the slot memory and then a compare
// and write. A walk ends at the root or at a node without children, or when
// a compare stops it; its last step issues the result.
// An insert runs the upward walk. An extract first reads the root and the
// last slot, then runs the downward walk, or goes straight to the result
// when it empties the heap. A replace first looks up the slot, then runs
// both walks. busy stays high until the result cycle, in which a new
// request may already be accepted.
// Reset clears the element count, presence bits, controller state and result outputs, not the memories.
`default_nettype none
module indexed_min_heap #(
    parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     start,
    output logic                                    busy,
    input  wire  [imh_pkg::REQ_BITS-1:0]            i_req_type,
    input  wire  [imh_pkg::ID_BITS-1:0]             i_elem_id,
    input  wire  [imh_pkg::KEY_PORT_BITS-1:0]       i_new_key,
    output logic                                    o_done,
    output logic [imh_pkg::STATUS_BITS-1:0]         o_status,
    output logic [imh_pkg::ID_BITS-1:0]             o_out_elem,
    output logic [imh_pkg::KEY_PORT_BITS-1:0]       o_out_key,
    output logic [imh_pkg::OCC_BITS-1:0]            o_occupancy
);
    imh_pkg::t_cmd w_cmd;
    imh_pkg::t_sts w_sts;

    imh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .busy       (busy)
    );

    imh_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_elem_id   (i_elem_id),
        .i_new_key   (i_new_key),
        .o_sts       (w_sts),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_out_elem  (o_out_elem),
        .o_out_key   (o_out_key),
        .o_occupancy (o_occupancy)
    );
endmodule
`default_nettype wire

// ===== hdl/imh_checker.sv =====
// Port-level checker for the indexed min-heap and its bind to the top level.
// It depends on imh_pkg and on the ports of indexed_min_heap.
`default_nettype none
module imh_checker #(
    parameter int CAPACITY = imh_pkg::CAPACITY_DEF
) (
    input wire                                     i_clk,
    input wire                                     i_rst_n,
    input wire                                     start,
    input wire                                     busy,
    input wire [imh_pkg::STATUS_BITS-1:0]          o_status,
    input wire                                     o_done,
    input wire [imh_pkg::ID_BITS-1:0]              o_out_elem,
    input wire [imh_pkg::KEY_PORT_BITS-1:0]        o_out_key,
    input wire [imh_pkg::OCC_BITS-1:0]             o_occupancy
);
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != imh_pkg::ST_OK) |-> (o_out_elem == '0) && (o_out_key == '0))
        else $error("Rejected request returned a nonzero element or key.");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == imh_pkg::ST_EMPTY) |-> (o_occupancy == '0))
        else $error("Empty status with nonzero occupancy.");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_occupancy) <= 32'(CAPACITY)))
        else $error("Occupancy beyond capacity.");

    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("Result beat without a request.");
endmodule

bind indexed_min_heap imh_checker #(.CAPACITY(CAPACITY)) u_imh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_status    (o_status),
    .o_done      (o_done),
    .o_out_elem  (o_out_elem),
    .o_out_key   (o_out_key),
    .o_occupancy (o_occupancy)
);
`default_nettype wire
